FILE: rtl/core/mhpq_pkg.sv
package mhpq_pkg;

   localparam int CAPACITY  = 256;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int IDX_W     = CNT_W + 1;

   localparam int REQ_TDATA_W = ((KEY_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((KEY_WIDTH + CNT_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_EXTRACT = 2'd1,
      MODE_DELETE  = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RD_ROOT,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT,
      RD_LAST,
      RD_SCAN
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_CUR,
      WR_RD,
      WR_LEFT
   } wr_sel_type;

   typedef enum logic [2:0] {
      POS_ROOT,
      POS_COUNT,
      POS_PARENT,
      POS_LEFT,
      POS_RIGHT,
      POS_SCAN
   } pos_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ONES,
      RES_RD
   } res_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_CHK,
      S_UP_CMP,
      S_DN_LOAD,
      S_DN_GET,
      S_DN_CHK,
      S_DN_L,
      S_DN_R,
      S_EX_ROOT,
      S_EX_LAST,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DEL_LAST,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        load_req;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        pos_en;
      pos_sel_type pos_sel;
      logic        cur_from_rd;
      logic        left_load;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        scan_clr;
      logic        scan_inc;
      logic        res_en;
      res_sel_type res_sel;
      status_type  res_status;
      logic        out_load;
   } mhpq_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     cnt_full;
      logic     cnt_zero;
      logic     pos_zero;
      logic     cur_lt_rd;
      logic     rd_lt_cur;
      logic     left_end;
      logic     right_in;
      logic     left_lt_cur;
      logic     right_best;
      logic     scan_end;
      logic     key_match;
      logic     scan_not_last;
   } mhpq_stat_type;

endpackage

FILE: rtl/core/mhpq_dp.sv
module mhpq_dp
   import mhpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_mode,
   input  logic [KEY_WIDTH-1:0]    req_key,
   input  mhpq_cmd_type            cmd,
   output mhpq_stat_type           stat,
   output logic [KEY_WIDTH-1:0]    out_result,
   output logic [1:0]              out_status,
   output logic [CNT_W-1:0]        out_occupancy
);

   logic [KEY_WIDTH-1:0] mem [CAPACITY];

   mode_type                    mode_ff;
   logic signed [KEY_WIDTH-1:0] cur_ff, cur_in;
   logic signed [KEY_WIDTH-1:0] left_ff;
   logic signed [KEY_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic [KEY_WIDTH-1:0]        res_ff, res_in;
   status_type                  stat_ff;
   logic [KEY_WIDTH-1:0]        out_result_ff;
   status_type                  out_status_ff;
   logic [CNT_W-1:0]            out_occ_ff;

   logic [IDX_W-1:0]            left_idx;
   logic [IDX_W-1:0]            right_idx;
   logic [ADDR_W-1:0]           pos_m1;
   logic [ADDR_W-1:0]           parent_idx;
   logic [CNT_W-1:0]            last_idx;
   logic [ADDR_W-1:0]           rd_addr;
   logic [KEY_WIDTH-1:0]        wr_data;
   logic signed [KEY_WIDTH-1:0] best_lc;

   // Children of pos are 2*pos+1 and 2*pos+2; the parent is (pos-1)/2.
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + IDX_W'(1);
   assign pos_m1     = pos_ff - ADDR_W'(1);
   assign parent_idx = {1'b0, pos_m1[ADDR_W-1:1]};
   assign last_idx   = count_ff - CNT_W'(1);
   assign best_lc    = (left_ff < cur_ff) ? left_ff : cur_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_ROOT:   rd_addr = '0;
         RD_PARENT: rd_addr = parent_idx;
         RD_LEFT:   rd_addr = left_idx[ADDR_W-1:0];
         RD_RIGHT:  rd_addr = right_idx[ADDR_W-1:0];
         RD_LAST:   rd_addr = last_idx[ADDR_W-1:0];
         RD_SCAN:   rd_addr = scan_ff[ADDR_W-1:0];
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_CUR:  wr_data = cur_ff;
         WR_RD:   wr_data = rd_data_ff;
         WR_LEFT: wr_data = left_ff;
         default: wr_data = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_en) begin
         case (cmd.pos_sel)
            POS_ROOT:   pos_in = '0;
            POS_COUNT:  pos_in = count_ff[ADDR_W-1:0];
            POS_PARENT: pos_in = parent_idx;
            POS_LEFT:   pos_in = left_idx[ADDR_W-1:0];
            POS_RIGHT:  pos_in = right_idx[ADDR_W-1:0];
            POS_SCAN:   pos_in = scan_ff[ADDR_W-1:0];
            default:    pos_in = pos_ff;
         endcase
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.load_req) begin
         cur_in = req_key;
      end else if (cmd.cur_from_rd) begin
         cur_in = rd_data_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = last_idx;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clr) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + CNT_W'(1);
      end
   end

   always_comb begin
      case (cmd.res_sel)
         RES_ZERO: res_in = '0;
         RES_ONES: res_in = '1;
         RES_RD:   res_in = rd_data_ff;
         default:  res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
      scan_ff <= scan_in;
      if (cmd.load_req) begin
         mode_ff <= mode_type'(req_mode);
      end
      if (cmd.left_load) begin
         left_ff <= rd_data_ff;
      end
      if (cmd.res_en) begin
         res_ff  <= res_in;
         stat_ff <= cmd.res_status;
      end
      if (cmd.out_load) begin
         out_result_ff <= res_ff;
         out_status_ff <= stat_ff;
         out_occ_ff    <= count_ff;
      end
   end

   always_comb begin
      stat.mode          = mode_ff;
      stat.cnt_full      = (count_ff == CNT_W'(CAPACITY));
      stat.cnt_zero      = (count_ff == '0);
      stat.pos_zero      = (pos_ff == '0);
      stat.cur_lt_rd     = (cur_ff < rd_data_ff);
      stat.rd_lt_cur     = (rd_data_ff < cur_ff);
      stat.left_end      = (left_idx >= IDX_W'(count_ff));
      stat.right_in      = (right_idx < IDX_W'(count_ff));
      stat.left_lt_cur   = (left_ff < cur_ff);
      stat.right_best    = (rd_data_ff < best_lc);
      stat.scan_end      = (scan_ff >= count_ff);
      stat.key_match     = (rd_data_ff == cur_ff);
      stat.scan_not_last = ((IDX_W'(scan_ff) + IDX_W'(1)) < IDX_W'(count_ff));
   end

   assign out_result    = out_result_ff;
   assign out_status    = out_status_ff;
   assign out_occupancy = out_occ_ff;

endmodule

FILE: rtl/core/mhpq_ctrl.sv
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  mhpq_stat_type stat,
   output mhpq_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_ROOT;
      cmd.wr_sel     = WR_CUR;
      cmd.pos_sel    = POS_ROOT;
      cmd.res_sel    = RES_ZERO;
      cmd.res_status = STAT_OK;
      req_tready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            cmd.res_en = 1'b1;
            case (stat.mode)
               MODE_INSERT: begin
                  if (stat.cnt_full) begin
                     cmd.res_status = STAT_FULL;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.pos_en  = 1'b1;
                     cmd.pos_sel = POS_COUNT;
                     cmd.cnt_inc = 1'b1;
                     state_in    = S_UP_CHK;
                  end
               end
               MODE_EXTRACT: begin
                  if (stat.cnt_zero) begin
                     cmd.res_status = STAT_EMPTY;
                     cmd.res_sel    = RES_ONES;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ROOT;
                     state_in   = S_EX_ROOT;
                  end
               end
               MODE_DELETE: begin
                  cmd.res_status = STAT_NOTFOUND;
                  cmd.scan_clr   = 1'b1;
                  state_in       = S_SCAN_RD;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         // Sift up keeps the moving key in a register and shifts parents
         // down into the hole; the key is written once at its final slot.
         S_UP_CHK: begin
            if (stat.pos_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_CUR;
               state_in   = (stat.mode == MODE_DELETE) ? S_DN_LOAD : S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.cur_lt_rd) begin
               cmd.wr_sel  = WR_RD;
               cmd.pos_en  = 1'b1;
               cmd.pos_sel = POS_PARENT;
               state_in    = S_UP_CHK;
            end else begin
               cmd.wr_sel = WR_CUR;
               state_in   = (stat.mode == MODE_DELETE) ? S_DN_LOAD : S_FINISH;
            end
         end

         // After a delete, the slot of the removed key is sifted down too,
         // starting from whatever the sift up left there.
         S_DN_LOAD: begin
            cmd.pos_en  = 1'b1;
            cmd.pos_sel = POS_SCAN;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_SCAN;
            state_in    = S_DN_GET;
         end

         S_DN_GET: begin
            cmd.cur_from_rd = 1'b1;
            state_in        = S_DN_CHK;
         end

         S_DN_CHK: begin
            if (stat.left_end) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_CUR;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_L;
            end
         end

         S_DN_L: begin
            cmd.left_load = 1'b1;
            if (stat.right_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_RIGHT;
               state_in   = S_DN_R;
            end else if (stat.rd_lt_cur) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_RD;
               cmd.pos_en  = 1'b1;
               cmd.pos_sel = POS_LEFT;
               state_in    = S_DN_CHK;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_CUR;
               state_in   = S_FINISH;
            end
         end

         // The right child wins only when strictly below the better of the
         // left child and the moving key.
         S_DN_R: begin
            cmd.wr_en = 1'b1;
            if (stat.right_best) begin
               cmd.wr_sel  = WR_RD;
               cmd.pos_en  = 1'b1;
               cmd.pos_sel = POS_RIGHT;
               state_in    = S_DN_CHK;
            end else if (stat.left_lt_cur) begin
               cmd.wr_sel  = WR_LEFT;
               cmd.pos_en  = 1'b1;
               cmd.pos_sel = POS_LEFT;
               state_in    = S_DN_CHK;
            end else begin
               cmd.wr_sel = WR_CUR;
               state_in   = S_FINISH;
            end
         end

         S_EX_ROOT: begin
            cmd.res_en  = 1'b1;
            cmd.res_sel = RES_RD;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_LAST;
            cmd.cnt_dec = 1'b1;
            state_in    = S_EX_LAST;
         end

         S_EX_LAST: begin
            cmd.cur_from_rd = 1'b1;
            cmd.pos_en      = 1'b1;
            cmd.pos_sel     = POS_ROOT;
            state_in        = S_DN_CHK;
         end

         S_SCAN_RD: begin
            if (stat.scan_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SCAN;
               state_in   = S_SCAN_CMP;
            end
         end

         S_SCAN_CMP: begin
            if (stat.key_match) begin
               cmd.res_en  = 1'b1;
               cmd.cnt_dec = 1'b1;
               if (stat.scan_not_last) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_LAST;
                  state_in   = S_DEL_LAST;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end

         S_DEL_LAST: begin
            cmd.cur_from_rd = 1'b1;
            cmd.pos_en      = 1'b1;
            cmd.pos_sel     = POS_SCAN;
            state_in        = S_UP_CHK;
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/core/min_heap_priority_queue_top.sv
// Binary min-heap priority queue of 256 signed 32-bit keys. Each request
// transaction carries an operation in req_tuser (insert, extract minimum,
// delete by value, or no-op) and a key in req_tdata, and yields exactly one
// response transaction with the extracted key, a status and the occupancy
// after the operation. One operation is processed at a time; a new request
// is taken as soon as the previous one has been moved into the response
// register, even if that response has not yet been taken. The key memory
// is single-port with registered read data. Insert sifts the new key up,
// extract sifts the last key down from the root, and delete scans the
// entries in store order, then sifts the refilled slot up and down.
// No clearing pass is needed after reset.
module min_heap_priority_queue_top
   import mhpq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] key_value
   input  logic [1:0]             req_tuser,   // [1:0] mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] result_value, [40:32] occupancy
   output logic [1:0]             rsp_tuser    // [1:0] status
);

   mhpq_cmd_type         cmd;
   mhpq_stat_type        stat;
   logic [KEY_WIDTH-1:0] out_result;
   logic [1:0]           out_status;
   logic [CNT_W-1:0]     out_occupancy;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mhpq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_mode      (req_tuser),
      .req_key       (req_tdata[KEY_WIDTH-1:0]),
      .cmd           (cmd),
      .stat          (stat),
      .out_result    (out_result),
      .out_status    (out_status),
      .out_occupancy (out_occupancy)
   );

   assign rsp_tdata = RSP_TDATA_W'({out_occupancy, out_result});
   assign rsp_tuser = out_status;

endmodule

FILE: rtl/core/mhpq_checker.sv
module mhpq_checker
   import mhpq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [1:0]             req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   logic rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Operations never overlap: a request is never taken back to back.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an operation is in flight");

   // An extract from an empty heap reports all ones and zero occupancy.
   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tuser == STAT_EMPTY |->
         rsp_tdata[KEY_WIDTH-1:0] == '1 &&
         rsp_tdata[KEY_WIDTH+CNT_W-1:KEY_WIDTH] == '0)
      else $error("empty status with wrong result or occupancy");

   // A refused insert only happens at full capacity.
   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tuser == STAT_FULL |->
         rsp_tdata[KEY_WIDTH+CNT_W-1:KEY_WIDTH] == CNT_W'(CAPACITY) &&
         rsp_tdata[KEY_WIDTH-1:0] == '0)
      else $error("full status below capacity");

endmodule

bind min_heap_priority_queue_top mhpq_checker u_checker (.*);
